[rtl/cdp_pkg.sv]
// ----------------------------------------------------------------------------
// cdp_pkg
// Shared types and constants of the channel duration profiler.
// ----------------------------------------------------------------------------
package cdp_pkg;

	localparam int CHANNELS = 32;
	localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	localparam logic [2:0] CMD_COUNT     = 3'd0;
	localparam logic [2:0] CMD_START     = 3'd1;
	localparam logic [2:0] CMD_END       = 3'd2;
	localparam logic [2:0] CMD_CLEAR     = 3'd3;
	localparam logic [2:0] CMD_CLEAR_ALL = 3'd4;
	localparam logic [2:0] CMD_READ      = 3'd5;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [4:0]  channel;
		logic [31:0] now;
	} cdp_req_t;

	typedef struct packed {
		logic [31:0] elapsed;
		logic [31:0] total_ticks;
		logic [31:0] event_total;
		logic        running;
	} cdp_res_t;

endpackage

[rtl/cdp_table.sv]
// ----------------------------------------------------------------------------
// cdp_table
// Per-channel profiling state with its read-modify-write update.
// ----------------------------------------------------------------------------
module cdp_table
	import cdp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     fire,
	input  cdp_req_t req,
	output cdp_res_t res
);

	logic [31:0]         stamp_q [CHANNELS];
	logic [31:0]         total_q [CHANNELS];
	logic [31:0]         count_q [CHANNELS];
	logic [CHANNELS-1:0] busy_q;

	logic [CH_W-1:0] idx;
	logic            hit;
	logic [31:0]     nxt_stamp;
	logic [31:0]     nxt_total;
	logic [31:0]     nxt_count;
	logic            nxt_busy;
	logic [31:0]     elapsed;

	assign idx = req.channel[CH_W-1:0];
	assign hit = 32'(req.channel) < 32'(CHANNELS);

	always_comb begin
		nxt_stamp = stamp_q[idx];
		nxt_total = total_q[idx];
		nxt_count = count_q[idx];
		nxt_busy  = busy_q[idx];
		elapsed   = '0;
		case (req.cmd)
			CMD_COUNT: begin
				nxt_count = count_q[idx] + 32'd1;
			end
			CMD_START: begin
				nxt_stamp = req.now;
				nxt_busy  = 1'b1;
			end
			CMD_END: begin
				// only a running channel closes an interval
				if (busy_q[idx]) begin
					elapsed   = req.now - stamp_q[idx];
					nxt_total = total_q[idx] + (req.now - stamp_q[idx]);
					nxt_count = count_q[idx] + 32'd1;
					nxt_busy  = 1'b0;
				end
			end
			CMD_CLEAR, CMD_CLEAR_ALL: begin
				nxt_stamp = '0;
				nxt_total = '0;
				nxt_count = '0;
				nxt_busy  = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		if (hit) begin
			res.elapsed     = elapsed;
			res.total_ticks = nxt_total;
			res.event_total = nxt_count;
			res.running     = nxt_busy;
		end else begin
			res = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				stamp_q[i] <= '0;
				total_q[i] <= '0;
				count_q[i] <= '0;
			end
		end else if (fire) begin
			if (req.cmd == CMD_CLEAR_ALL) begin
				busy_q <= '0;
				for (int i = 0; i < CHANNELS; i++) begin
					stamp_q[i] <= '0;
					total_q[i] <= '0;
					count_q[i] <= '0;
				end
			end else if (hit) begin
				stamp_q[idx] <= nxt_stamp;
				total_q[idx] <= nxt_total;
				count_q[idx] <= nxt_count;
				busy_q[idx]  <= nxt_busy;
			end
		end
	end

endmodule

[rtl/channel_duration_profiler.sv]
// ----------------------------------------------------------------------------
// channel_duration_profiler
// Table of profiling channels: event counts and start/end interval totals.
// ----------------------------------------------------------------------------
// Each request carries a command, a channel and the current tick value and
// yields exactly one result: the elapsed ticks of a closed interval (zero
// otherwise) and the channel's total ticks, event count and running flag as
// they stand after the request. The block takes one request per cycle while
// the result register is free or drains. The request is held in an input
// register; then the channel table is read, updated and the result
// registered in the same cycle. The next request sees the updated table, so
// back-to-back requests to one channel need no forwarding. Clear all zeroes
// every channel at once. All sums wrap at 32 bits; a channel index
// at or beyond the table depth is ignored and returns an all-zero result.
// ----------------------------------------------------------------------------
module channel_duration_profiler
	import cdp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  cmd,
	input  logic [4:0]  channel,
	input  logic [31:0] now,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] elapsed,
	output logic [31:0] total_ticks,
	output logic [31:0] event_total,
	output logic        running
);

	logic     valid_s1;
	cdp_req_t req_s1;
	logic     out_valid_q;
	cdp_res_t res_q;
	cdp_res_t res;
	logic     advance;

	// advance the held request when the result register is free or drains
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	// hold the accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1.cmd     <= cmd;
			req_s1.channel <= channel;
			req_s1.now     <= now;
		end
	end

	// table update happens exactly when the result is captured
	cdp_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (valid_s1 && advance),
		.req    (req_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			res_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign elapsed     = res_q.elapsed;
	assign total_ticks = res_q.total_ticks;
	assign event_total = res_q.event_total;
	assign running     = res_q.running;

endmodule
